// File: design/rgb_fade_perceptual_pwm_macros.svh
// ----------------------------------------------------------------------------
// RGB fade engine assertion macros
// Shared concurrent assertion forms, clocked on clk and gated by rst_n.
// ----------------------------------------------------------------------------
`ifndef RGB_FADE_PERCEPTUAL_PWM_MACROS_SVH
`define RGB_FADE_PERCEPTUAL_PWM_MACROS_SVH

// Antecedent implies consequent in the next cycle.
`define RFP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rfp: next-cycle check failed");

// Condition must never hold.
`define RFP_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("rfp: forbidden condition seen");

`endif

// File: design/rfp_pkg.sv
// ----------------------------------------------------------------------------
// RGB fade engine package
// Fixed widths, curve constants, control types and the curve table builder.
// ----------------------------------------------------------------------------
package rfp_pkg;

  localparam int VIS_BITS   = 10;
  localparam int FRAC_BITS  = 12;
  localparam int STEP_BITS  = 16;
  localparam int PWM_BITS   = 12;
  localparam int LVL_BITS   = VIS_BITS + FRAC_BITS;
  localparam int DLT_BITS   = LVL_BITS + 1;
  localparam int PWM_MAX    = 4095;
  localparam int FULL_VIS   = (1 << VIS_BITS) - 1;
  localparam logic [LVL_BITS-1:0] FULL_LEVEL = LVL_BITS'(FULL_VIS) << FRAC_BITS;

  localparam logic [63:0] LN10_Q28 = 64'd618095479;
  localparam logic [63:0] LN8_Q28  = 64'd558195838;
  localparam logic [63:0] MULT_RG  = 64'(PWM_MAX / 9);
  localparam logic [63:0] MULT_B   = 64'(PWM_MAX / 7);
  localparam logic [63:0] Z_DIV    = 64'(FULL_VIS * 100);

  localparam int DIV_CYCLES = LVL_BITS;
  localparam int CNT_BITS   = $clog2(DIV_CYCLES);

  typedef logic [FULL_VIS:0][PWM_BITS-1:0] rom_t;

  typedef struct packed {
    logic ld_in;
    logic snap;
    logic div_init;
    logic div_step;
    logic rom_rd;
    logic set_step;
    logic tick_upd;
    logic out_ld;
  } rfp_cmd_t;

  typedef struct packed {
    logic mode;
    logic n_zero;
  } rfp_sts_t;

  function automatic rom_t build_rom(input logic [63:0] pct, input logic [63:0] ln_base,
                                     input logic [63:0] mult);
    rom_t        rom;
    logic [63:0] z, sum, term, e20, prod;
    logic        done;
    for (int v = 0; v <= FULL_VIS; v++) begin
      z    = (64'(v) * pct * ln_base) / Z_DIV;
      sum  = 64'd1 << 28;
      term = 64'd1 << 28;
      done = 1'b0;
      for (int k = 1; k <= 48; k++) begin
        if (!done) begin
          term = ((term * z) >> 28) / 64'(k);
          if (term == 64'd0) done = 1'b1;
          else sum = sum + term;
        end
      end
      e20  = (sum + 64'd128) >> 8;
      prod = (mult * (e20 - (64'd1 << 20))) >> 20;
      if (prod > 64'(PWM_MAX)) prod = 64'(PWM_MAX);
      rom[v] = PWM_BITS'(64'(PWM_MAX) - prod);
    end
    return rom;
  endfunction

endpackage

// File: design/rfp_ctrl.sv
// ----------------------------------------------------------------------------
// RGB fade engine controller
// Sequences load, delta division, curve lookup and result handoff.
// ----------------------------------------------------------------------------
`include "rgb_fade_perceptual_pwm_macros.svh"

module rfp_ctrl
  import rfp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  rfp_sts_t sts,
  output rfp_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_ROM  = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]          state_r, state_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                in_fire;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign in_fire   = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.ld_in = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.mode) begin
          state_nxt = S_ROM;
        end else if (sts.n_zero) begin
          cmd.snap  = 1'b1;
          state_nxt = S_ROM;
        end else begin
          cmd.div_init = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_BITS'(DIV_CYCLES - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_ROM;
        end
      end
      S_ROM: begin
        // Capture the lookup of the current colour; the tick update lands on
        // the same edge and stays out of this beat.
        cmd.rom_rd   = 1'b1;
        cmd.tick_upd = sts.mode;
        cmd.set_step = !sts.mode && !sts.n_zero;
        state_nxt    = S_RD;
      end
      S_RD: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_ld    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `RFP_ASSERT_NEXT(a_busy_after_accept, in_fire, state_r == S_DEC)
  `RFP_ASSERT_NEXT(a_out_loaded, cmd.out_ld, out_valid_r)
  `RFP_ASSERT_NEVER(a_cnt_range, cnt_r > CNT_BITS'(DIV_CYCLES - 1))

endmodule

// File: design/rfp_dp.sv
// ----------------------------------------------------------------------------
// RGB fade engine datapath
// Levels, deltas, three serial dividers, curve tables and result registers.
// ----------------------------------------------------------------------------
module rfp_dp
  import rfp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  rfp_cmd_t             cmd,
  output rfp_sts_t             sts,
  input  logic                 in_mode,
  input  logic [VIS_BITS-1:0]  in_target_red,
  input  logic [VIS_BITS-1:0]  in_target_green,
  input  logic [VIS_BITS-1:0]  in_target_blue,
  input  logic [STEP_BITS-1:0] in_fade_steps,
  output logic [PWM_BITS-1:0]  out_pwm_red,
  output logic [PWM_BITS-1:0]  out_pwm_green,
  output logic [PWM_BITS-1:0]  out_pwm_blue,
  output logic                 out_fading
);

  localparam rom_t ROM_R = build_rom(64'd100, LN10_Q28, MULT_RG);
  localparam rom_t ROM_G = build_rom(64'd92,  LN10_Q28, MULT_RG);
  localparam rom_t ROM_B = build_rom(64'd76,  LN8_Q28,  MULT_B);

  logic                           mode_r;
  logic [STEP_BITS-1:0]           n_r;
  logic [2:0][VIS_BITS-1:0]       tgt_r;
  logic [2:0][VIS_BITS-1:0]       goal_r;
  logic [2:0][LVL_BITS-1:0]       level_r;
  logic [2:0][DLT_BITS-1:0]       step_r;
  logic [STEP_BITS-1:0]           ticks_r;
  logic [2:0][LVL_BITS-1:0]       q_r;
  logic [2:0][STEP_BITS-1:0]      rem_r;
  logic [2:0]                     neg_r;
  logic [2:0][PWM_BITS-1:0]       rd_r;
  logic [2:0][PWM_BITS-1:0]       pwm_r;
  logic                           fading_r;

  assign sts.mode   = mode_r;
  assign sts.n_zero = (n_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      mode_r <= in_mode;
      n_r    <= in_fade_steps;
      tgt_r  <= {in_target_blue, in_target_green, in_target_red};
    end
  end

  // Lookup on the integer part of each level; hold it until the beat is loaded.
  always_ff @(posedge clk) begin
    if (cmd.rom_rd) begin
      rd_r[0] <= ROM_R[level_r[0][LVL_BITS-1:FRAC_BITS]];
      rd_r[1] <= ROM_G[level_r[1][LVL_BITS-1:FRAC_BITS]];
      rd_r[2] <= ROM_B[level_r[2][LVL_BITS-1:FRAC_BITS]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      pwm_r    <= rd_r;
      fading_r <= (ticks_r != '0);
    end
  end

  assign out_pwm_red   = pwm_r[0];
  assign out_pwm_green = pwm_r[1];
  assign out_pwm_blue  = pwm_r[2];
  assign out_fading    = fading_r;

  logic last_tick;
  assign last_tick = (ticks_r == STEP_BITS'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r <= '0;
    end else if (cmd.snap) begin
      ticks_r <= '0;
    end else if (cmd.set_step) begin
      ticks_r <= n_r;
    end else if (cmd.tick_upd && ticks_r != '0) begin
      ticks_r <= ticks_r - 1'b1;
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_ch
    logic signed [LVL_BITS+1:0] num;
    logic        [LVL_BITS+1:0] mag;
    logic        [STEP_BITS:0]  rem_sh;
    logic                       fit;
    logic signed [LVL_BITS+1:0] sum;
    logic        [LVL_BITS-1:0] clamped;

    assign num = $signed({2'b00, tgt_r[c], {FRAC_BITS{1'b0}}})
               - $signed({2'b00, level_r[c]});
    assign mag = num[LVL_BITS+1] ? -num : num;

    assign rem_sh = {rem_r[c], q_r[c][LVL_BITS-1]};
    assign fit    = (rem_sh >= {1'b0, n_r});

    assign sum = $signed({2'b00, level_r[c]}) + $signed({step_r[c][DLT_BITS-1], step_r[c]});
    always_comb begin
      if (sum < 0) clamped = '0;
      else if (sum > $signed({2'b00, FULL_LEVEL})) clamped = FULL_LEVEL;
      else clamped = sum[LVL_BITS-1:0];
    end

    // Restoring division of the delta magnitude, one quotient bit a cycle.
    always_ff @(posedge clk) begin
      if (cmd.div_init) begin
        q_r[c]   <= mag[LVL_BITS-1:0];
        rem_r[c] <= '0;
        neg_r[c] <= num[LVL_BITS+1];
      end else if (cmd.div_step) begin
        q_r[c]   <= {q_r[c][LVL_BITS-2:0], fit};
        rem_r[c] <= fit ? STEP_BITS'(rem_sh - {1'b0, n_r}) : rem_sh[STEP_BITS-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        level_r[c] <= '0;
        step_r[c]  <= '0;
        goal_r[c]  <= '0;
      end else if (cmd.snap) begin
        goal_r[c]  <= tgt_r[c];
        level_r[c] <= {tgt_r[c], {FRAC_BITS{1'b0}}};
        step_r[c]  <= '0;
      end else if (cmd.set_step) begin
        goal_r[c] <= tgt_r[c];
        step_r[c] <= neg_r[c] ? -{1'b0, q_r[c]} : {1'b0, q_r[c]};
      end else if (cmd.tick_upd && ticks_r != '0) begin
        // Snap to the goal on the final tick.
        level_r[c] <= last_tick ? {goal_r[c], {FRAC_BITS{1'b0}}} : clamped;
      end
    end
  end

endmodule

// File: design/rgb_fade_perceptual_pwm.sv
// ----------------------------------------------------------------------------
// RGB fade engine with perceptual PWM curve
// After a tick or an immediate load is accepted the controller passes the
// decode, lookup, read and output states and then raises out_valid; a fading
// load adds the bit-serial divider state after decode. One item is in flight:
// in_ready returns in the cycle after the result is loaded, and output waits
// while a previous beat is unread. Reset (rst_n low, synchronous) clears
// colour, deltas, goals and the tick count; curve tables are constant.
// ----------------------------------------------------------------------------
module rgb_fade_perceptual_pwm
  import rfp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_mode,
  input  logic [VIS_BITS-1:0]  in_target_red,
  input  logic [VIS_BITS-1:0]  in_target_green,
  input  logic [VIS_BITS-1:0]  in_target_blue,
  input  logic [STEP_BITS-1:0] in_fade_steps,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PWM_BITS-1:0]  out_pwm_red,
  output logic [PWM_BITS-1:0]  out_pwm_green,
  output logic [PWM_BITS-1:0]  out_pwm_blue,
  output logic                 out_fading
);

  // Controller drives commands; datapath reports mode and zero step count.
  rfp_cmd_t cmd;
  rfp_sts_t sts;

  rfp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath holds the colour state, dividers, curve tables and result beat.
  rfp_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_mode         (in_mode),
    .in_target_red   (in_target_red),
    .in_target_green (in_target_green),
    .in_target_blue  (in_target_blue),
    .in_fade_steps   (in_fade_steps),
    .out_pwm_red     (out_pwm_red),
    .out_pwm_green   (out_pwm_green),
    .out_pwm_blue    (out_pwm_blue),
    .out_fading      (out_fading)
  );

endmodule
